// File: rtl/lnt_pkg.sv
// Shared types and constants for the line and triangle rasterizer.
// Used by the channel interfaces and by every rasterizer module.
package lnt_pkg;

  localparam int unsigned COORD_W         = 9;
  localparam int unsigned RASTER_SIZE_DEF = 512;

  typedef enum logic [1:0] {
    ACT_STEP = 2'd0,
    ACT_LINE = 2'd1,
    ACT_TRI  = 2'd2
  } action_e;

  // Edge numbers within a shape
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [1:0] action;
    coord_t     ax;
    coord_t     ay;
    coord_t     bx;
    coord_t     by_coord;
    coord_t     cx;
    coord_t     cy;
  } cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   edge_done;
    logic   shape_done;
  } pix_t;

  // Walk parameters of one edge, major axis increasing
  typedef struct packed {
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    coord_t delta_major;
    coord_t delta_minor;
    logic   minor_down;
    logic   steep;
  } edge_t;

endpackage

// File: rtl/lnt_ifs.sv
// Valid/ready channel interfaces for the rasterizer command and pixel streams.
// Depends on lnt_pkg for the coordinate type.
interface lnt_cmd_if import lnt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  coord_t     ax;
  coord_t     ay;
  coord_t     bx;
  coord_t     by_coord;
  coord_t     cx;
  coord_t     cy;

  modport source (output valid, action, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, action, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface lnt_pix_if import lnt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   edge_done;
  logic   shape_done;

  modport source (output valid, pixel_x, pixel_y, edge_done, shape_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, edge_done, shape_done, output ready);
endinterface

// File: rtl/lnt_edge_setup.sv
// Combinational edge setup: orders two endpoints for a Bresenham walk.
// Depends on lnt_pkg (coord_t, edge_t).
module lnt_edge_setup import lnt_pkg::*; (
  input  coord_t x0_i,
  input  coord_t y0_i,
  input  coord_t x1_i,
  input  coord_t y1_i,
  output edge_t  edge_o
);

  logic [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic               steep;
  coord_t             u0, v0, u1, v1;
  logic               swap;
  coord_t             minor_end;

  always_comb begin
    dx  = {1'b0, x1_i} - {1'b0, x0_i};
    dy  = {1'b0, y1_i} - {1'b0, y0_i};
    adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep = ady > adx;

    // Walk along y for steep edges
    u0 = steep ? y0_i : x0_i;
    v0 = steep ? x0_i : y0_i;
    u1 = steep ? y1_i : x1_i;
    v1 = steep ? x1_i : y1_i;

    // Order endpoints so the major coordinate increases
    swap = u0 > u1;
    edge_o.major_pos   = swap ? u1 : u0;
    edge_o.major_end   = swap ? u0 : u1;
    edge_o.minor_pos   = swap ? v1 : v0;
    minor_end          = swap ? v0 : v1;
    edge_o.delta_major = edge_o.major_end - edge_o.major_pos;
    edge_o.delta_minor = steep ? adx : ady;
    edge_o.minor_down  = minor_end < edge_o.minor_pos;
    edge_o.steep       = steep;
  end

endmodule

// File: rtl/lnt_walker.sv
// Rasterizer state and one-step Bresenham update per command.
// Depends on lnt_pkg and lnt_edge_setup.
module lnt_walker import lnt_pkg::*; #(
  parameter int unsigned RASTER_SIZE = RASTER_SIZE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output pix_t res_o
);

  localparam int unsigned ErrW = COORD_W + 1;
  localparam int unsigned SumW = COORD_W + 3;

  function automatic coord_t clamp_coord(coord_t v);
    if (32'(v) >= RASTER_SIZE) begin
      return COORD_W'(RASTER_SIZE - 1);
    end
    return v;
  endfunction

  // Vertex registers: only read after a start has written them
  coord_t va_x_q, va_y_q, vb_x_q, vb_y_q, vc_x_q, vc_y_q;

  edge_t                 edge_q, edge_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic [1:0]            edge_idx_q, edge_idx_d;
  logic                  tri_q, tri_d;
  logic                  active_q, active_d;

  logic   start;
  coord_t ca_x, ca_y, cb_x, cb_y, cc_x, cc_y;
  coord_t s_x0, s_y0, s_x1, s_y1;
  edge_t  setup_edge;
  logic   last;
  logic   final_edge;
  logic signed [SumW-1:0] err_sum, err_sub;
  logic   minor_step;

  assign ca_x = clamp_coord(cmd_i.ax);
  assign ca_y = clamp_coord(cmd_i.ay);
  assign cb_x = clamp_coord(cmd_i.bx);
  assign cb_y = clamp_coord(cmd_i.by_coord);
  assign cc_x = clamp_coord(cmd_i.cx);
  assign cc_y = clamp_coord(cmd_i.cy);

  assign start = (cmd_i.action == ACT_LINE) || (cmd_i.action == ACT_TRI);

  // Setup source: new vertices on a start, else the following stored edge
  always_comb begin
    if (start) begin
      s_x0 = ca_x;   s_y0 = ca_y;   s_x1 = cb_x;   s_y1 = cb_y;
    end else if (edge_idx_q == EDGE_AB) begin
      s_x0 = vb_x_q; s_y0 = vb_y_q; s_x1 = vc_x_q; s_y1 = vc_y_q;
    end else begin
      s_x0 = vc_x_q; s_y0 = vc_y_q; s_x1 = va_x_q; s_y1 = va_y_q;
    end
  end

  lnt_edge_setup u_setup (
    .x0_i   (s_x0),
    .y0_i   (s_y0),
    .x1_i   (s_x1),
    .y1_i   (s_y1),
    .edge_o (setup_edge)
  );

  assign last       = edge_q.major_pos >= edge_q.major_end;
  assign final_edge = !tri_q || (edge_idx_q == EDGE_CA);

  always_comb begin
    err_sum    = SumW'(err_q) + $signed({2'b00, edge_q.delta_minor, 1'b0});
    minor_step = err_sum >= $signed({3'b000, edge_q.delta_major});
    err_sub    = err_sum - $signed({2'b00, edge_q.delta_major, 1'b0});
  end

  always_comb begin
    edge_d      = edge_q;
    err_d       = err_q;
    edge_idx_d  = edge_idx_q;
    tri_d       = tri_q;
    active_d    = active_q;
    res_valid_o = 1'b0;

    res_o.pixel_x    = edge_q.steep ? edge_q.minor_pos : edge_q.major_pos;
    res_o.pixel_y    = edge_q.steep ? edge_q.major_pos : edge_q.minor_pos;
    res_o.edge_done  = last;
    res_o.shape_done = last && final_edge;

    if (fire_i) begin
      case (cmd_i.action)
        ACT_LINE, ACT_TRI: begin
          tri_d      = cmd_i.action == ACT_TRI;
          edge_idx_d = EDGE_AB;
          active_d   = 1'b1;
          edge_d     = setup_edge;
          err_d      = '0;
        end
        ACT_STEP: begin
          if (active_q) begin
            res_valid_o = 1'b1;
            if (last) begin
              if (final_edge) begin
                active_d = 1'b0;
              end else begin
                edge_idx_d = edge_idx_q + 2'd1;
                edge_d     = setup_edge;
                err_d      = '0;
              end
            end else begin
              edge_d.major_pos = edge_q.major_pos + COORD_W'(1);
              if (minor_step) begin
                edge_d.minor_pos = edge_q.minor_down ? edge_q.minor_pos - COORD_W'(1)
                                                     : edge_q.minor_pos + COORD_W'(1);
                err_d = err_sub[ErrW-1:0];
              end else begin
                err_d = err_sum[ErrW-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q     <= '0;
      err_q      <= '0;
      edge_idx_q <= EDGE_AB;
      tri_q      <= 1'b0;
      active_q   <= 1'b0;
    end else begin
      edge_q     <= edge_d;
      err_q      <= err_d;
      edge_idx_q <= edge_idx_d;
      tri_q      <= tri_d;
      active_q   <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && start) begin
      va_x_q <= ca_x;
      va_y_q <= ca_y;
      vb_x_q <= cb_x;
      vb_y_q <= cb_y;
      vc_x_q <= cc_x;
      vc_y_q <= cc_y;
    end
  end

  // A single-point edge has a zero major delta and keeps the error at zero
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q >= -$signed({1'b0, edge_q.delta_major}))
              && ((err_q < $signed({1'b0, edge_q.delta_major})) || (err_q == '0)))
    else $error("error term left its range");

  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> edge_q.major_pos <= edge_q.major_end)
    else $error("major position passed edge end");

  a_delta_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> edge_q.delta_minor <= edge_q.delta_major)
    else $error("minor delta exceeds major delta");

  a_shape_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.shape_done) |=> !active_q)
    else $error("shape still active after its last pixel");

  a_tri_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !tri_q) |-> edge_idx_q == EDGE_AB)
    else $error("line walked past its only edge");

endmodule

// File: rtl/line_and_triangle_rasterizer.sv
// Top level of the line and triangle rasterizer: command/pixel channels,
// input and output registers. Depends on lnt_pkg, lnt_ifs and lnt_walker.
//
// Usage:
//   cmd_i carries commands. ACT_LINE and ACT_TRI latch the vertices (A, B and,
//   for a triangle, C; coordinates at or beyond RASTER_SIZE saturate) and
//   set up the first edge; they produce no pixel and abort any shape in
//   progress. Each ACT_STEP then produces exactly one pixel on pix_o, with
//   edge_done on the last pixel of an edge and shape_done on the last pixel
//   of the line or triangle (edges A-B, B-C, C-A). A step while idle and
//   the unused action code produce nothing.
//   Throughput: one command per cycle while pix_o accepts; each step is one add and
//   compare in the walker's single registered update.
//   Path: a step transaction passes through the input register, then the
//   walker's update and the output register, before its pixel is on pix_o.
//   Reset: asynchronous, active low; the block comes up idle with both
//   registers empty.
//   Stall: while pix_o is held off, the output register and the input
//   register hold their contents and cmd_i.ready drops once both are full.
module line_and_triangle_rasterizer import lnt_pkg::*; #(
  parameter int unsigned RASTER_SIZE = RASTER_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lnt_cmd_if.sink   cmd_i,
  lnt_pix_if.source pix_o
);

  logic in_valid_q;
  cmd_t in_q;
  logic out_valid_q;
  pix_t out_q;
  logic advance;
  logic accept;
  logic res_valid;
  pix_t res;

  // Output register free or draining this cycle
  assign advance     = !out_valid_q || pix_o.ready;
  assign cmd_i.ready = !in_valid_q || advance;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.action   <= cmd_i.action;
      in_q.ax       <= cmd_i.ax;
      in_q.ay       <= cmd_i.ay;
      in_q.bx       <= cmd_i.bx;
      in_q.by_coord <= cmd_i.by_coord;
      in_q.cx       <= cmd_i.cx;
      in_q.cy       <= cmd_i.cy;
    end
  end

  lnt_walker #(
    .RASTER_SIZE (RASTER_SIZE)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_valid_q && advance),
    .cmd_i       (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_x    = out_q.pixel_x;
  assign pix_o.pixel_y    = out_q.pixel_y;
  assign pix_o.edge_done  = out_q.edge_done;
  assign pix_o.shape_done = out_q.shape_done;

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pix_o.ready) |=> out_valid_q && $stable(out_q))
    else $error("pixel dropped or changed while stalled");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !cmd_i.ready)
    else $error("command taken while input register blocked");

  a_shape_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.shape_done) |-> out_q.edge_done)
    else $error("shape end without edge end");

endmodule
